// File: design/mains_crossing_phase_cut_assert.svh
// assertion macros for the checker file of the phase cut block
`ifndef MAINS_CROSSING_PHASE_CUT_ASSERT_SVH
`define MAINS_CROSSING_PHASE_CUT_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define MCPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define MCPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mcpc_pkg.sv
// shared types and constants of the mains crossing phase cut block
package mcpc_pkg;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLT_ZERO      = 2'd0,
        REG_AMP_ZERO       = 2'd1,
        REG_ONE_PERCENT_US = 2'd2
    } cfg_reg_t;

    // register reset values
    localparam int ZERO_RST_VAL        = 512;
    localparam int ONE_PERCENT_RST_VAL = 100;
    localparam int ZERO_MIN_W          = 10;

    // cut percentage and on-time limit
    localparam int            PCT_W    = 7;
    localparam int            LIMIT_W  = PCT_W + CFG_W;
    localparam logic [PCT_W-1:0] FULL_CUT = 7'd100;

    // reported delay width
    localparam int DELAY_W = 32;

    // crossing codes
    typedef logic signed [1:0] cross_t;
    localparam cross_t CROSS_NONE    = 2'sb00;
    localparam cross_t CROSS_RISING  = 2'sb01;
    localparam cross_t CROSS_FALLING = 2'sb11;

endpackage

// File: design/mains_crossing_phase_cut.sv
// mains zero-cross detector, phase delay timer and leading-edge triac cut
//
//  channel   ports                          direction  transaction
//  --------  -----------------------------  ---------  -----------------------------
//  input     s_valid s_ready s_* fields     in         one sample pair, time, percent
//  result    m_valid m_ready m_* fields     out        one result per input item
//  config    cfg_wr_en cfg_index cfg_wr_data in        one register write, no wait
//
// One item per cycle sustained while the result register is not stalled.
// The input register holds the item and its precomputed on-time limit (percent times
// one_percent_us); one compare and subtract stage then updates state and the result register.
// A stalled result register stops the input register; new input is still taken while the
// result waits as long as the input register is empty or drains in the same cycle.
// Synchronous active-low reset clears state and restores register defaults.
module mains_crossing_phase_cut #(
    parameter int ADC_BITS  = 10,
    parameter int TIME_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // configuration
    input  logic                              cfg_wr_en,
    input  logic [mcpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcpc_pkg::CFG_W-1:0]        cfg_wr_data,

    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ADC_BITS-1:0]               s_volt_sample,
    input  logic [ADC_BITS-1:0]               s_amp_sample,
    input  logic [TIME_BITS-1:0]              s_time_us,
    input  logic [mcpc_pkg::PCT_W-1:0]        s_cut_percent,

    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output mcpc_pkg::cross_t                  m_volt_cross,
    output mcpc_pkg::cross_t                  m_amp_cross,
    output logic                              m_triac_on,
    output logic                              m_delay_valid,
    output logic [mcpc_pkg::DELAY_W-1:0]      m_phase_delay_us
);

    localparam int ZERO_W  = (ADC_BITS > mcpc_pkg::ZERO_MIN_W) ? ADC_BITS : mcpc_pkg::ZERO_MIN_W;
    localparam int CMP_W   = (TIME_BITS > mcpc_pkg::LIMIT_W) ? TIME_BITS : mcpc_pkg::LIMIT_W;
    localparam int DEXT_W  = (TIME_BITS > mcpc_pkg::DELAY_W) ? TIME_BITS : mcpc_pkg::DELAY_W;

    // crossing of one channel against its midpoint
    function automatic mcpc_pkg::cross_t detect_cross(
        input logic [ADC_BITS-1:0] sample,
        input logic [ADC_BITS-1:0] prev,
        input logic [ZERO_W-1:0]   zero
    );
        logic [ZERO_W-1:0] s_ext;
        logic [ZERO_W-1:0] p_ext;
        mcpc_pkg::cross_t  dir;
        s_ext = ZERO_W'(sample);
        p_ext = ZERO_W'(prev);
        dir   = mcpc_pkg::CROSS_NONE;
        if (s_ext > zero && p_ext <= zero) begin
            dir = mcpc_pkg::CROSS_RISING;
        end else if (s_ext < zero && p_ext >= zero) begin
            dir = mcpc_pkg::CROSS_FALLING;
        end
        return dir;
    endfunction

    // configuration registers
    logic [ZERO_W-1:0]              volt_zero_reg;
    logic [ZERO_W-1:0]              amp_zero_reg;
    logic [mcpc_pkg::CFG_W-1:0]     one_pct_reg;

    // input stage
    logic                           in_valid_reg;
    logic [ADC_BITS-1:0]            in_volt_reg;
    logic [ADC_BITS-1:0]            in_amp_reg;
    logic [TIME_BITS-1:0]           in_time_reg;
    logic                           in_full_reg;
    logic [mcpc_pkg::LIMIT_W-1:0]   in_limit_reg;
    logic [mcpc_pkg::PCT_W-1:0]     pct_sat;
    logic [mcpc_pkg::LIMIT_W-1:0]   limit_next;

    // block state
    logic [ADC_BITS-1:0]            prev_volt_reg, prev_volt_next;
    logic [ADC_BITS-1:0]            prev_amp_reg, prev_amp_next;
    logic                           triac_off_reg, triac_off_next;
    logic                           timing_reg, timing_next;
    logic [TIME_BITS-1:0]           rise_time_reg, rise_time_next;
    logic [TIME_BITS-1:0]           off_start_reg, off_start_next;
    logic [TIME_BITS-1:0]           last_delay_reg, last_delay_next;

    // result stage
    logic                           out_valid_reg;
    mcpc_pkg::cross_t               vc_next, ac_next;
    mcpc_pkg::cross_t               volt_cross_reg, amp_cross_reg;
    logic                           delay_valid_next, delay_valid_reg;
    logic [mcpc_pkg::DELAY_W-1:0]   delay_out_reg;
    logic [DEXT_W-1:0]              delay_ext;
    logic [TIME_BITS-1:0]           elapsed;

    logic                           advance;
    logic                           in_take;

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volt_zero_reg <= ZERO_W'(mcpc_pkg::ZERO_RST_VAL);
            amp_zero_reg  <= ZERO_W'(mcpc_pkg::ZERO_RST_VAL);
            one_pct_reg   <= mcpc_pkg::CFG_W'(mcpc_pkg::ONE_PERCENT_RST_VAL);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mcpc_pkg::REG_VOLT_ZERO:      volt_zero_reg <= ZERO_W'(cfg_wr_data[ADC_BITS-1:0]);
                mcpc_pkg::REG_AMP_ZERO:       amp_zero_reg  <= ZERO_W'(cfg_wr_data[ADC_BITS-1:0]);
                mcpc_pkg::REG_ONE_PERCENT_US: one_pct_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // saturated percent and on-time limit, computed on the way in
    always_comb begin
        pct_sat    = (s_cut_percent > mcpc_pkg::FULL_CUT) ? mcpc_pkg::FULL_CUT : s_cut_percent;
        limit_next = mcpc_pkg::LIMIT_W'(pct_sat) * mcpc_pkg::LIMIT_W'(one_pct_reg);
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_volt_reg  <= s_volt_sample;
            in_amp_reg   <= s_amp_sample;
            in_time_reg  <= s_time_us;
            in_full_reg  <= (pct_sat == mcpc_pkg::FULL_CUT);
            in_limit_reg <= limit_next;
        end
    end

    // crossing detection, delay timing and triac cut
    always_comb begin
        prev_volt_next   = prev_volt_reg;
        prev_amp_next    = prev_amp_reg;
        triac_off_next   = triac_off_reg;
        timing_next      = timing_reg;
        rise_time_next   = rise_time_reg;
        off_start_next   = off_start_reg;
        last_delay_next  = last_delay_reg;
        vc_next          = mcpc_pkg::CROSS_NONE;
        ac_next          = mcpc_pkg::CROSS_NONE;
        delay_valid_next = 1'b0;
        elapsed          = in_time_reg - off_start_reg;

        // crossings only while the triac conducts
        if (!triac_off_reg) begin
            vc_next        = detect_cross(in_volt_reg, prev_volt_reg, volt_zero_reg);
            ac_next        = detect_cross(in_amp_reg, prev_amp_reg, amp_zero_reg);
            prev_volt_next = in_volt_reg;
            prev_amp_next  = in_amp_reg;
        end

        // voltage rise to current rise timer
        if (vc_next == mcpc_pkg::CROSS_RISING && !timing_reg) begin
            rise_time_next = in_time_reg;
            timing_next    = 1'b1;
        end else if (ac_next == mcpc_pkg::CROSS_RISING && timing_reg) begin
            last_delay_next  = in_time_reg - rise_time_reg;
            timing_next      = 1'b0;
            delay_valid_next = 1'b1;
        end

        // leading-edge cut
        if (in_full_reg) begin
            triac_off_next = 1'b1;
        end else if (vc_next != mcpc_pkg::CROSS_NONE) begin
            triac_off_next = 1'b1;
            off_start_next = in_time_reg;
        end else if (CMP_W'(elapsed) > CMP_W'(in_limit_reg)) begin
            triac_off_next = 1'b0;
        end

        delay_ext = DEXT_W'(last_delay_next);
    end

    // state update, one item per advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_volt_reg  <= '0;
            prev_amp_reg   <= '0;
            triac_off_reg  <= 1'b0;
            timing_reg     <= 1'b0;
            rise_time_reg  <= '0;
            off_start_reg  <= '0;
            last_delay_reg <= '0;
        end else if (advance) begin
            prev_volt_reg  <= prev_volt_next;
            prev_amp_reg   <= prev_amp_next;
            triac_off_reg  <= triac_off_next;
            timing_reg     <= timing_next;
            rise_time_reg  <= rise_time_next;
            off_start_reg  <= off_start_next;
            last_delay_reg <= last_delay_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            volt_cross_reg  <= vc_next;
            amp_cross_reg   <= ac_next;
            delay_valid_reg <= delay_valid_next;
            delay_out_reg   <= delay_ext[mcpc_pkg::DELAY_W-1:0];
        end
    end

    // triac level follows state, which only changes with a new result
    assign m_valid          = out_valid_reg;
    assign m_volt_cross     = volt_cross_reg;
    assign m_amp_cross      = amp_cross_reg;
    assign m_triac_on       = !triac_off_reg;
    assign m_delay_valid    = delay_valid_reg;
    assign m_phase_delay_us = delay_out_reg;

endmodule

// File: design/mcpc_checker.sv
// port-level checker for the mains crossing phase cut block, with its bind
`include "mains_crossing_phase_cut_assert.svh"

module mcpc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input mcpc_pkg::cross_t                m_volt_cross,
    input mcpc_pkg::cross_t                m_amp_cross,
    input logic                            m_triac_on,
    input logic                            m_delay_valid,
    input logic [mcpc_pkg::DELAY_W-1:0]    m_phase_delay_us
);

    // a stalled result holds its transaction
    `MCPC_ASSERT_NXT(a_hold_stall, m_valid && !m_ready, m_valid && $stable(m_phase_delay_us) && $stable(m_volt_cross) && $stable(m_amp_cross) && $stable(m_delay_valid), "stalled result changed")

    // a voltage crossing always leaves the triac off
    `MCPC_ASSERT_IMP(a_cross_cuts, m_valid && m_volt_cross != mcpc_pkg::CROSS_NONE, !m_triac_on, "triac on after voltage crossing")

    // a new delay ends only on a rising current crossing
    `MCPC_ASSERT_IMP(a_delay_on_rise, m_valid && m_delay_valid, m_amp_cross == mcpc_pkg::CROSS_RISING, "delay without current rise")

    // crossing codes never take the unused pattern
    `MCPC_ASSERT_IMP(a_cross_code, m_valid, m_volt_cross != 2'sb10 && m_amp_cross != 2'sb10, "bad crossing code")

endmodule

bind mains_crossing_phase_cut mcpc_checker u_mcpc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_volt_cross     (m_volt_cross),
    .m_amp_cross      (m_amp_cross),
    .m_triac_on       (m_triac_on),
    .m_delay_valid    (m_delay_valid),
    .m_phase_delay_us (m_phase_delay_us)
);
